>>> design/wsht_pkg.sv
// ----------------------------------------------------------------------------
// wsht_pkg
// Types and codes shared by the window stack hit test block.
// ----------------------------------------------------------------------------
`default_nettype none

package wsht_pkg;

    localparam int CMD_W = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_CREATE = 3'd0,
        CMD_DESTROY = 3'd1,
        CMD_FRONT = 3'd2,
        CMD_GEOM = 3'd3,
        CMD_MOUSE = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK = 2'd0,
        ST_NO_SLOT = 2'd1,
        ST_INACTIVE = 2'd2,
        ST_MISS = 2'd3
    } status_t;

    localparam logic [1:0] REG_SCREEN_W = 2'd0;
    localparam logic [1:0] REG_SCREEN_H = 2'd1;
    localparam logic [1:0] REG_TITLE_H = 2'd2;

    localparam logic signed [12:0] CASCADE_X0 = 13'sd40;
    localparam logic signed [12:0] CASCADE_Y0 = 13'sd50;
    localparam logic signed [12:0] CASCADE_STEP = 13'sd30;
    localparam logic [11:0] CLAMP_W_MARGIN = 12'd40;
    localparam logic [11:0] CLAMP_H_MARGIN = 12'd60;

    typedef struct packed {
        logic signed [12:0] x;
        logic signed [12:0] y;
        logic [11:0] w;
        logic [11:0] h;
        logic [15:0] id;
    } rect_t;

endpackage

`default_nettype wire

>>> design/wsht_ram.sv
// ----------------------------------------------------------------------------
// wsht_ram
// Single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module wsht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> design/window_stack_hit_test.sv
// ----------------------------------------------------------------------------
// window_stack_hit_test
// Window slot table with a bottom-to-top stacking list and mouse hit testing.
// ----------------------------------------------------------------------------
// Each command word yields one result word. The rectangles and ids live in one
// RAM and the stacking list in another, both with registered read data, so a
// command walks the stacking list one entry at a time. Destroy and bring to
// front walk the list entry by entry, and a mouse event scans it entry by
// entry; a button press on a hit adds the raise walk. No new command word is
// taken until the result word has moved into the output register.
`default_nettype none

module window_stack_hit_test #(
    parameter int SLOT_COUNT = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [2:0]  command,
    input  wire logic [3:0]  slot,
    input  wire logic signed [12:0] pos_x,
    input  wire logic signed [12:0] pos_y,
    input  wire logic [11:0] size_w,
    input  wire logic [11:0] size_h,
    input  wire logic        fullscreen,
    input  wire logic [2:0]  button,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       status,
    output logic [3:0]       hit_slot,
    output logic [15:0]      window_id,
    output logic signed [13:0] local_x,
    output logic signed [13:0] local_y,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [11:0] cfg_data
);
    import wsht_pkg::*;

    localparam int SW = $clog2(SLOT_COUNT);
    localparam int CW = $clog2(SLOT_COUNT + 1);
    localparam int RW = $bits(rect_t);

    typedef enum logic [3:0] {
        S_IDLE, S_DISPATCH, S_CREATE, S_RECT_RD, S_GEOM,
        S_WALK_RD, S_WALK_CHK, S_SHIFT_RD, S_SHIFT_WR, S_PUSH, S_MOUSE_RD,
        S_MOUSE_RECT, S_MOUSE_CHK, S_DONE
    } state_t;

    state_t state_reg;
    logic [11:0] scr_w_reg, scr_h_reg;
    logic [7:0] title_reg;
    logic [SLOT_COUNT-1:0] used_reg;
    logic [CW-1:0] count_reg;
    logic [15:0] id_ctr_reg;
    logic signed [13:0] casc_x_reg, casc_y_reg;

    cmd_t cmd_reg;
    logic [3:0] slot_in_reg;
    logic signed [12:0] px_reg, py_reg;
    logic [11:0] sw_reg, sh_reg;
    logic full_reg;
    logic [2:0] btn_reg;

    logic [SW-1:0] tgt_reg;
    logic [CW-1:0] k_reg;
    logic raise_reg;

    logic [1:0] st_reg;
    logic [3:0] hs_reg;
    logic [15:0] wid_reg;
    logic signed [13:0] lx_reg, ly_reg;

    logic r_we;
    logic [SW-1:0] r_waddr, r_raddr;
    rect_t r_wdata, r_rdata;
    logic s_we;
    logic [SW-1:0] s_waddr, s_raddr, s_rdata, s_wdata;

    wsht_ram #(.WIDTH(RW), .DEPTH(SLOT_COUNT)) u_rect (
        .clk(clk), .we(r_we), .waddr(r_waddr), .wdata(r_wdata),
        .raddr(r_raddr), .rdata(r_rdata)
    );

    wsht_ram #(.WIDTH(SW), .DEPTH(SLOT_COUNT)) u_stack (
        .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
        .raddr(s_raddr), .rdata(s_rdata)
    );

    logic [SW-1:0] free_idx;
    logic free_any;
    always_comb
    begin
        free_idx = '0;
        free_any = 1'b0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--)
        begin
            if (!used_reg[i])
            begin
                free_idx = SW'(i);
                free_any = 1'b1;
            end
        end
    end

    logic slot_ok;
    logic [SW-1:0] slot_idx;
    assign slot_idx = SW'(slot_in_reg);
    assign slot_ok = ({28'd0, slot_in_reg} < 32'(SLOT_COUNT)) && used_reg[slot_idx];

    // Create placement.
    logic [11:0] cw, ch, cw_cl, ch_cl;
    logic signed [12:0] cpx, cpy, cx_base, cy_base;
    logic signed [14:0] sum_x, sum_y;
    logic explicit_pos;
    always_comb
    begin
        cw = full_reg ? scr_w_reg : sw_reg;
        ch = full_reg ? scr_h_reg : sh_reg;
        cpx = full_reg ? 13'sd0 : px_reg;
        cpy = full_reg ? 13'sd0 : py_reg;
        explicit_pos = !cpx[12] && !cpy[12];
        sum_x = 15'(casc_x_reg) + $signed({3'd0, cw});
        sum_y = 15'(casc_y_reg) + $signed({3'd0, ch});
        cx_base = (sum_x > $signed({3'd0, scr_w_reg})) ? CASCADE_X0 : 13'(casc_x_reg);
        cy_base = (sum_y > $signed({3'd0, scr_h_reg})) ? CASCADE_Y0 : 13'(casc_y_reg);
        cw_cl = cw;
        if (cw > scr_w_reg)
        begin
            cw_cl = (scr_w_reg > CLAMP_W_MARGIN) ? scr_w_reg - CLAMP_W_MARGIN : 12'd0;
        end
        ch_cl = ch;
        if (ch > scr_h_reg)
        begin
            ch_cl = (scr_h_reg > CLAMP_H_MARGIN) ? scr_h_reg - CLAMP_H_MARGIN : 12'd0;
        end
    end

    // Hit test on the rectangle read back from memory.
    logic signed [13:0] ex, ey, dx, dy;
    logic hit;
    always_comb
    begin
        ex = 14'(r_rdata.x) + $signed({2'd0, r_rdata.w});
        ey = 14'(r_rdata.y) + $signed({2'd0, r_rdata.h});
        dx = 14'(px_reg) - 14'(r_rdata.x);
        dy = 14'(py_reg) - 14'(r_rdata.y) - $signed({6'd0, title_reg});
        hit = used_reg[s_rdata] && (px_reg >= r_rdata.x) && (14'(px_reg) < ex)
            && (py_reg >= r_rdata.y) && (14'(py_reg) < ey);
    end

    logic [CW-1:0] km1;
    assign km1 = k_reg - CW'(1);

    always_comb
    begin
        r_we = 1'b0;
        r_waddr = tgt_reg;
        r_wdata = '{x: px_reg, y: py_reg, w: sw_reg, h: sh_reg, id: r_rdata.id};
        r_raddr = s_rdata;
        s_we = 1'b0;
        s_waddr = tgt_reg;
        s_wdata = tgt_reg;
        s_raddr = k_reg[SW-1:0];
        case (state_reg)
            S_CREATE:
            begin
                r_we = 1'b1;
                r_waddr = free_idx;
                r_wdata.x = explicit_pos ? cpx : cx_base;
                r_wdata.y = explicit_pos ? cpy : cy_base;
                r_wdata.w = cw_cl;
                r_wdata.h = ch_cl;
                r_wdata.id = id_ctr_reg;
            end
            S_RECT_RD:
            begin
                r_raddr = tgt_reg;
            end
            S_GEOM:
            begin
                r_we = 1'b1;
            end
            S_SHIFT_RD:
            begin
                s_raddr = SW'(k_reg + CW'(1));
            end
            S_SHIFT_WR:
            begin
                s_we = 1'b1;
                s_waddr = k_reg[SW-1:0];
                s_wdata = s_rdata;
            end
            S_PUSH:
            begin
                s_we = 1'b1;
                s_waddr = count_reg[SW-1:0];
            end
            S_MOUSE_RD:
            begin
                s_raddr = km1[SW-1:0];
            end
            default:
            begin
            end
        endcase
    end

    assign in_stall = (state_reg != S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            scr_w_reg <= 12'd640;
            scr_h_reg <= 12'd480;
            title_reg <= 8'd30;
            used_reg <= '0;
            count_reg <= '0;
            id_ctr_reg <= 16'd1;
            casc_x_reg <= 14'(CASCADE_X0);
            casc_y_reg <= 14'(CASCADE_Y0);
            out_valid <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall && state_reg != S_DONE)
            begin
                out_valid <= 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_SCREEN_W: scr_w_reg <= cfg_data;
                    REG_SCREEN_H: scr_h_reg <= cfg_data;
                    REG_TITLE_H: title_reg <= cfg_data[7:0];
                    default:
                    begin
                    end
                endcase
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        cmd_reg <= cmd_t'(command);
                        slot_in_reg <= slot;
                        px_reg <= pos_x;
                        py_reg <= pos_y;
                        sw_reg <= size_w;
                        sh_reg <= size_h;
                        full_reg <= fullscreen;
                        btn_reg <= button;
                        st_reg <= ST_OK;
                        hs_reg <= '0;
                        wid_reg <= '0;
                        lx_reg <= '0;
                        ly_reg <= '0;
                        state_reg <= S_DISPATCH;
                    end
                end
                S_DISPATCH:
                begin
                    tgt_reg <= slot_idx;
                    k_reg <= '0;
                    raise_reg <= (cmd_reg == CMD_FRONT);
                    case (cmd_reg)
                        CMD_CREATE:
                        begin
                            if (free_any)
                            begin
                                state_reg <= S_CREATE;
                            end
                            else
                            begin
                                st_reg <= ST_NO_SLOT;
                                state_reg <= S_DONE;
                            end
                        end
                        CMD_DESTROY, CMD_FRONT, CMD_GEOM:
                        begin
                            if (!slot_ok)
                            begin
                                st_reg <= ST_INACTIVE;
                                state_reg <= S_DONE;
                            end
                            else if (cmd_reg == CMD_GEOM)
                            begin
                                state_reg <= S_RECT_RD;
                            end
                            else
                            begin
                                state_reg <= S_WALK_RD;
                            end
                        end
                        CMD_MOUSE:
                        begin
                            k_reg <= count_reg;
                            state_reg <= (count_reg == '0) ? S_DONE : S_MOUSE_RD;
                            st_reg <= ST_MISS;
                        end
                        default:
                        begin
                            state_reg <= S_DONE;
                        end
                    endcase
                end
                S_CREATE:
                begin
                    used_reg[free_idx] <= 1'b1;
                    id_ctr_reg <= id_ctr_reg + 16'd1;
                    if (!explicit_pos)
                    begin
                        casc_x_reg <= 14'(cx_base) + 14'(CASCADE_STEP);
                        casc_y_reg <= 14'(cy_base) + 14'(CASCADE_STEP);
                    end
                    hs_reg <= 4'(free_idx);
                    wid_reg <= id_ctr_reg;
                    tgt_reg <= free_idx;
                    state_reg <= S_PUSH;
                end
                S_RECT_RD:
                begin
                    state_reg <= S_GEOM;
                end
                S_GEOM:
                begin
                    state_reg <= S_DONE;
                end
                S_WALK_RD:
                begin
                    state_reg <= S_WALK_CHK;
                end
                S_WALK_CHK:
                begin
                    if (s_rdata == tgt_reg)
                    begin
                        count_reg <= count_reg - CW'(1);
                        state_reg <= S_SHIFT_RD;
                    end
                    else if (k_reg + CW'(1) >= count_reg)
                    begin
                        state_reg <= raise_reg ? S_PUSH : S_DONE;
                    end
                    else
                    begin
                        k_reg <= k_reg + CW'(1);
                        state_reg <= S_WALK_RD;
                    end
                end
                S_SHIFT_RD:
                begin
                    if (k_reg >= count_reg)
                    begin
                        if (raise_reg)
                        begin
                            state_reg <= S_PUSH;
                        end
                        else
                        begin
                            used_reg[tgt_reg] <= 1'b0;
                            state_reg <= S_DONE;
                        end
                    end
                    else
                    begin
                        state_reg <= S_SHIFT_WR;
                    end
                end
                S_SHIFT_WR:
                begin
                    k_reg <= k_reg + CW'(1);
                    state_reg <= S_SHIFT_RD;
                end
                S_PUSH:
                begin
                    if (count_reg < CW'(SLOT_COUNT))
                    begin
                        count_reg <= count_reg + CW'(1);
                    end
                    state_reg <= S_DONE;
                end
                S_MOUSE_RD:
                begin
                    k_reg <= km1;
                    state_reg <= S_MOUSE_RECT;
                end
                S_MOUSE_RECT:
                begin
                    state_reg <= S_MOUSE_CHK;
                end
                S_MOUSE_CHK:
                begin
                    if (hit)
                    begin
                        st_reg <= ST_OK;
                        hs_reg <= 4'(s_rdata);
                        wid_reg <= r_rdata.id;
                        lx_reg <= dx;
                        ly_reg <= dy;
                        tgt_reg <= s_rdata;
                        k_reg <= '0;
                        if (btn_reg != 3'd0)
                        begin
                            raise_reg <= 1'b1;
                            state_reg <= S_WALK_RD;
                        end
                        else
                        begin
                            state_reg <= S_DONE;
                        end
                    end
                    else
                    begin
                        state_reg <= (k_reg == '0) ? S_DONE : S_MOUSE_RD;
                    end
                end
                S_DONE:
                begin
                    if (!out_valid || !out_stall)
                    begin
                        out_valid <= 1'b1;
                        status <= st_reg;
                        hit_slot <= hs_reg;
                        window_id <= wid_reg;
                        local_x <= lx_reg;
                        local_y <= ly_reg;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> in_stall)
        else $error("input taken while busy");
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(SLOT_COUNT))
        else $error("stack count overflow");
    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> !(state_reg == S_IDLE))
        else $error("command dropped");

endmodule

`default_nettype wire

>>> dv/wsht_checker.sv
// ----------------------------------------------------------------------------
// wsht_checker
// Watches the command, result and register channels of the window stack hit
// test block, keeps its own window table and stacking list, and compares every
// result word with the predicted one.
// ----------------------------------------------------------------------------
`default_nettype none

module wsht_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic        in_stall,
    input  wire logic [2:0]  command,
    input  wire logic [3:0]  slot,
    input  wire logic signed [12:0] pos_x,
    input  wire logic signed [12:0] pos_y,
    input  wire logic [11:0] size_w,
    input  wire logic [11:0] size_h,
    input  wire logic        fullscreen,
    input  wire logic [2:0]  button,
    input  wire logic        out_valid,
    input  wire logic        out_stall,
    input  wire logic [1:0]  status,
    input  wire logic [3:0]  hit_slot,
    input  wire logic [15:0] window_id,
    input  wire logic signed [13:0] local_x,
    input  wire logic signed [13:0] local_y,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [11:0] cfg_data,
    output int               fail_count,
    output int               pending,
    output int               result_count,
    output int               hit_count
);
    import wsht_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSLOT = 16;

    typedef struct packed {
        logic [1:0]  st;
        logic [3:0]  hs;
        logic [15:0] wid;
        logic [13:0] lx;
        logic [13:0] ly;
    } result_t;

    result_t result_queue[$];

    int scr_w, scr_h, title_h;
    bit used[NSLOT];
    int wx[NSLOT], wy[NSLOT], ww[NSLOT], wh[NSLOT];
    int wid_of[NSLOT];
    int stack_list[$];
    int next_id, casc_x, casc_y;

    function automatic void raise_window(input int s);
        int idx[$];
        idx = stack_list.find_first_index(e) with (e == s);
        if (idx.size() > 0) stack_list.delete(idx[0]);
        stack_list.push_back(s);
    endfunction

    function automatic result_t predict_window_command(input logic [2:0] cmd,
            input int s, input int px_in, input int py_in, input int sw_in,
            input int sh_in, input bit full, input int btn);
        result_t r;
        int f, px, py, sw, sh, hit, idx[$];
        r = '0;
        px = px_in;
        py = py_in;
        sw = sw_in;
        sh = sh_in;
        if (cmd == CMD_CREATE) begin
            f = NSLOT;
            for (int i = NSLOT - 1; i >= 0; i--)
                if (!used[i]) f = i;
            if (f == NSLOT) begin
                r.st = ST_NO_SLOT;
            end
            else begin
                used[f] = 1;
                wid_of[f] = next_id;
                next_id = (next_id + 1) & 16'hffff;
                if (full) begin
                    px = 0; py = 0; sw = scr_w; sh = scr_h;
                end
                if (px >= 0 && py >= 0) begin
                    wx[f] = px; wy[f] = py;
                end
                else begin
                    if (casc_x + sw > scr_w) casc_x = 40;
                    if (casc_y + sh > scr_h) casc_y = 50;
                    wx[f] = casc_x; wy[f] = casc_y;
                    casc_x += 30; casc_y += 30;
                end
                if (sw > scr_w) sw = (scr_w - 40 < 0) ? 0 : scr_w - 40;
                if (sh > scr_h) sh = (scr_h - 60 < 0) ? 0 : scr_h - 60;
                ww[f] = sw; wh[f] = sh;
                stack_list.push_back(f);
                r.st = ST_OK;
                r.hs = 4'(f);
                r.wid = 16'(wid_of[f]);
            end
        end
        else if (cmd == CMD_DESTROY || cmd == CMD_FRONT || cmd == CMD_GEOM) begin
            if (!used[s]) begin
                r.st = ST_INACTIVE;
            end
            else if (cmd == CMD_DESTROY) begin
                idx = stack_list.find_first_index(e) with (e == s);
                if (idx.size() > 0) stack_list.delete(idx[0]);
                used[s] = 0;
            end
            else if (cmd == CMD_FRONT) begin
                raise_window(s);
            end
            else begin
                wx[s] = px; wy[s] = py; ww[s] = sw; wh[s] = sh;
            end
        end
        else if (cmd == CMD_MOUSE) begin
            hit = NSLOT;
            for (int k = stack_list.size() - 1; k >= 0 && hit == NSLOT; k--) begin
                f = stack_list[k];
                if (used[f] && px >= wx[f] && px < wx[f] + ww[f]
                        && py >= wy[f] && py < wy[f] + wh[f])
                    hit = f;
            end
            if (hit == NSLOT) begin
                r.st = ST_MISS;
            end
            else begin
                r.lx = 14'(px - wx[hit]);
                r.ly = 14'(py - wy[hit] - title_h);
                r.hs = 4'(hit);
                r.wid = 16'(wid_of[hit]);
                hit_count++;
                if (btn != 0) raise_window(hit);
            end
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t got, want;
        if (!rst_n) begin
            scr_w = 640; scr_h = 480; title_h = 30;
            for (int i = 0; i < NSLOT; i++) used[i] = 0;
            stack_list.delete();
            result_queue.delete();
            next_id = 1; casc_x = 40; casc_y = 50;
            fail_count = 0; pending = 0; result_count = 0; hit_count = 0;
        end
        else begin
            if (out_valid && !out_stall) begin
                got = '{status, hit_slot, window_id, local_x, local_y};
                result_count++;
                if (result_queue.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result word %h", got);
                end
                else begin
                    want = result_queue.pop_front();
                    if (got !== want) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"mismatch (exp/got): status %0d/%0d slot %0d/%0d",
                                " id %0d/%0d lx %0d/%0d ly %0d/%0d"},
                                want.st, got.st, want.hs, got.hs, want.wid, got.wid,
                                $signed(want.lx), $signed(got.lx),
                                $signed(want.ly), $signed(got.ly));
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_SCREEN_W: scr_w = int'(cfg_data);
                    REG_SCREEN_H: scr_h = int'(cfg_data);
                    REG_TITLE_H: title_h = int'(cfg_data[7:0]);
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
                result_queue.push_back(predict_window_command(command, int'(slot),
                    int'(pos_x), int'(pos_y), int'(size_w), int'(size_h), fullscreen,
                    int'(button)));
            pending = result_queue.size();
        end
    end
endmodule

`default_nettype wire

>>> dv/tb_window_stack_hit_test.sv
// ----------------------------------------------------------------------------
// tb_window_stack_hit_test
// Drives directed and random window commands and mouse words into the block
// under several screen settings with random idling on both sides; the
// checker beside the block predicts and compares every result word.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_window_stack_hit_test;
    import wsht_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic clk, rst_n;
    logic in_valid, in_stall, out_valid, out_stall, fullscreen;
    logic [2:0] command, button;
    logic [3:0] slot, hit_slot;
    logic signed [12:0] pos_x, pos_y;
    logic [11:0] size_w, size_h, cfg_data;
    logic [1:0] status, cfg_index;
    logic [15:0] window_id;
    logic signed [13:0] local_x, local_y;
    logic cfg_valid, cfg_ready;
    int fail_count, pending, result_count, hit_count;
    int cycle_count, sent;
    bit calm;

    window_stack_hit_test u_top (.*);
    wsht_checker u_chk (.*);

    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 2000000) begin
            $display("timeout");
            $display("** window_stack_hit_test: FAILED **");
            $finish;
        end
    end

    always @(posedge clk)
        out_stall <= calm ? 1'b0 : ($urandom_range(99) < 32);

    task automatic send_word(input logic [2:0] c, input int s,
            input int px, input int py, input int w, input int h,
            input int fs, input int b);
        while (!calm && $urandom_range(99) < 32) begin
            in_valid <= 0;
            @(posedge clk);
        end
        command <= c; slot <= 4'(s); pos_x <= 13'(px); pos_y <= 13'(py);
        size_w <= 12'(w); size_h <= 12'(h); fullscreen <= fs[0]; button <= 3'(b);
        in_valid <= 1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sent++;
    endtask

    task automatic write_reg(input logic [1:0] idx, input int d);
        in_valid <= 0;
        while (pending != 0) @(posedge clk);
        repeat (60) @(posedge clk);
        cfg_index <= idx; cfg_data <= 12'(d); cfg_valid <= 1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 0;
    endtask

    task automatic random_word();
        int r, px, py;
        r = $urandom_range(99);
        px = $urandom_range(99) < 15 ? int'($signed(13'($urandom))) : $urandom_range(700);
        py = $urandom_range(99) < 15 ? int'($signed(13'($urandom))) : $urandom_range(520);
        if (r < 22)
            send_word(CMD_CREATE, $urandom, px, py,
                $urandom_range(99) < 10 ? $urandom_range(4095) : $urandom_range(300),
                $urandom_range(99) < 10 ? $urandom_range(4095) : $urandom_range(300),
                int'($urandom_range(99) < 10), $urandom);
        else if (r < 34)
            send_word(CMD_DESTROY, $urandom, px, py, $urandom, $urandom, $urandom, $urandom);
        else if (r < 46)
            send_word(CMD_FRONT, $urandom, px, py, $urandom, $urandom, $urandom, $urandom);
        else if (r < 56)
            send_word(CMD_GEOM, $urandom, px, py, $urandom_range(400),
                $urandom_range(400), $urandom, $urandom);
        else if (r < 97)
            send_word(CMD_MOUSE, $urandom, px, py, $urandom, $urandom, $urandom, $urandom);
        else
            send_word(3'($urandom_range(5, 7)), $urandom, px, py, $urandom, $urandom,
                $urandom, $urandom);
    endtask

    initial
    begin
        cycle_count = 0; sent = 0; calm = 0;
        rst_n = 0; in_valid = 0; out_stall = 0; cfg_valid = 0;
        command = 0; slot = 0; pos_x = 0; pos_y = 0; size_w = 0; size_h = 0;
        fullscreen = 0; button = 0; cfg_index = 0; cfg_data = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        send_word(CMD_MOUSE, 0, 10, 10, 0, 0, 0, 1);
        send_word(CMD_DESTROY, 15, 0, 0, 0, 0, 0, 0);
        send_word(CMD_FRONT, 3, 0, 0, 0, 0, 0, 0);
        send_word(CMD_GEOM, 0, 0, 0, 0, 0, 0, 0);
        send_word(CMD_CREATE, 0, 0, 0, 4095, 4095, 0, 0);
        send_word(CMD_CREATE, 0, -4096, 4095, 100, 100, 0, 0);
        send_word(CMD_CREATE, 0, 5, -1, 600, 440, 0, 0);
        send_word(CMD_CREATE, 0, 4095, 4095, 10, 10, 1, 0);
        send_word(CMD_MOUSE, 0, 0, 0, 0, 0, 0, 0);
        send_word(CMD_MOUSE, 0, 100, 100, 0, 0, 0, 7);
        send_word(CMD_FRONT, 1, 0, 0, 0, 0, 0, 0);
        send_word(CMD_GEOM, 2, -4096, -4096, 4095, 4095, 0, 0);
        send_word(CMD_MOUSE, 0, -4096, -4096, 0, 0, 0, 4);
        send_word(CMD_MOUSE, 0, 4095, 4095, 0, 0, 0, 2);
        send_word(CMD_DESTROY, 3, 0, 0, 0, 0, 0, 0);
        send_word(3'd7, 0, 1, 1, 1, 1, 1, 1);
        for (int i = 0; i < 14; i++) send_word(CMD_CREATE, 0, -1, -1, 50, 50, 0, 0);
        send_word(CMD_CREATE, 0, 0, 0, 1, 1, 0, 0);

        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: begin
                    write_reg(REG_SCREEN_W, 64); write_reg(REG_SCREEN_H, 64);
                    write_reg(REG_TITLE_H, 255);
                end
                1: begin
                    write_reg(REG_SCREEN_W, 4095); write_reg(REG_SCREEN_H, 4095);
                    write_reg(REG_TITLE_H, 0);
                end
                2: begin
                    write_reg(REG_SCREEN_W, 640); write_reg(REG_SCREEN_H, 480);
                    write_reg(REG_TITLE_H, 30);
                end
                3: begin
                    write_reg(REG_SCREEN_W, $urandom_range(64, 4095));
                    write_reg(REG_SCREEN_H, $urandom_range(64, 4095));
                    write_reg(REG_TITLE_H, $urandom_range(255));
                end
                default: begin
                    write_reg(REG_SCREEN_W, 800); write_reg(REG_SCREEN_H, 600);
                end
            endcase
            calm = (phase == 2);
            for (int n = 0; n < 240; n++) random_word();
            calm = 0;
        end

        in_valid <= 0;
        while (pending != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        $display("Sent %0d command words, checked %0d result words, %0d mouse hits.",
            sent, result_count, hit_count);
        $display("Screen settings covered the register extremes and several midpoints.");
        if (fail_count == 0)
            $display("** window_stack_hit_test: PASSED **");
        else
            $display("** window_stack_hit_test: FAILED **");
        $finish;
    end
endmodule

`default_nettype wire

>>> files.f
design/wsht_pkg.sv
design/wsht_ram.sv
design/window_stack_hit_test.sv
dv/wsht_checker.sv
dv/tb_window_stack_hit_test.sv
